// ----- hw/rtl/ppd_pkg.sv -----
// shared widths, codes and payload types of the periodic pair distance block
// no dependencies; used by every module of the block
`default_nettype none

package ppd_pkg;

  // atom index range and widths of the data path
  localparam int ATOM_INDEX_COUNT = 128;
  localparam int INDEX_W = $clog2(ATOM_INDEX_COUNT);
  localparam int COORD_W = 24;
  localparam int AXES = 3;
  localparam int SQ_W = 2 * COORD_W;
  localparam int ROOT_W = COORD_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int DIST_W = 24;

  // root bits resolved in each square root stage
  localparam int ROOT_BITS_PER_STAGE = 2;
  localparam int ROOT_STAGES = ROOT_W / ROOT_BITS_PER_STAGE;

  // half a box in Q0.24
  localparam logic [COORD_W-1:0] HALF_BOX = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOND_CUTOFF = 2'd1;
  localparam logic [DIST_W-1:0] BOX_LENGTH_RESET = 24'd65536;
  localparam logic [DIST_W-1:0] BOND_CUTOFF_RESET = 24'd137626;

  typedef logic [AXES-1:0][COORD_W-1:0] coord_vec_t;

  typedef struct packed {
    logic [INDEX_W-1:0] center;
    logic [INDEX_W-1:0] partner;
  } index_pair_t;

  // front end to square root
  typedef struct packed {
    logic [SQ_W-1:0] sum;
    index_pair_t     idx;
  } sum_item_t;

  // square root to scaling
  typedef struct packed {
    logic [ROOT_W-1:0] root;
    index_pair_t       idx;
  } root_item_t;

  // final result
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [DIST_W-1:0] graph;
    logic              bonded;
    index_pair_t       idx;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ppd_front.sv -----
// front end: minimum image per axis, squares, and sum of squares (3 stages)
// depends on ppd_pkg
`default_nettype none

module ppd_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ppd_pkg::coord_vec_t center_i,
  input  wire ppd_pkg::coord_vec_t partner_i,
  input  wire ppd_pkg::index_pair_t idx_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ppd_pkg::sum_item_t      out_item_o
);

  // nearest image magnitude from the difference taken modulo one box
  function automatic logic [ppd_pkg::COORD_W-1:0] image_mag(
    input logic [ppd_pkg::COORD_W-1:0] c,
    input logic [ppd_pkg::COORD_W-1:0] p
  );
    logic [ppd_pkg::COORD_W-1:0] u;
    u = c - p;
    if (u > ppd_pkg::HALF_BOX) begin
      return ppd_pkg::COORD_W'(0) - u;
    end
    return u;
  endfunction

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic [ppd_pkg::AXES-1:0][ppd_pkg::COORD_W-1:0] mag_q;
  logic [ppd_pkg::AXES-1:0][ppd_pkg::SQ_W-1:0] sq_q;
  ppd_pkg::index_pair_t idx1_q, idx2_q;
  ppd_pkg::sum_item_t   item_q;

  // stage handshake: a stage moves when empty or when its successor moves
  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 1: minimum image magnitudes
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      for (int a = 0; a < ppd_pkg::AXES; a++) begin
        mag_q[a] <= image_mag(center_i[a], partner_i[a]);
      end
      idx1_q <= idx_i;
    end
  end

  // stage 2: one square per axis
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      for (int a = 0; a < ppd_pkg::AXES; a++) begin
        sq_q[a] <= ppd_pkg::SQ_W'(mag_q[a]) * ppd_pkg::SQ_W'(mag_q[a]);
      end
      idx2_q <= idx1_q;
    end
  end

  // stage 3: sum of squares, at most 3 * 2^46 so it fits
  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      item_q.sum <= sq_q[0] + sq_q[1] + sq_q[2];
      item_q.idx <= idx2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_item_o = item_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ppd_root.sv -----
// pipelined floor square root, two result bits per stage
// depends on ppd_pkg
`default_nettype none

module ppd_root (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ppd_pkg::sum_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ppd_pkg::root_item_t     out_item_o
);

  typedef struct packed {
    logic [ppd_pkg::SQ_W-1:0]   rad;
    logic [ppd_pkg::REM_W-1:0]  rem;
    logic [ppd_pkg::ROOT_W-1:0] root;
  } step_t;

  // one restoring step: bring down two radicand bits, try root*4+1
  function automatic step_t sqrt_step(input step_t cur);
    step_t nxt;
    logic [ppd_pkg::REM_W-1:0] rem_t;
    logic [ppd_pkg::REM_W-1:0] trial;
    rem_t = {cur.rem[ppd_pkg::REM_W-3:0], cur.rad[ppd_pkg::SQ_W-1 -: 2]};
    trial = {cur.root, 2'b01};
    nxt.rad = {cur.rad[ppd_pkg::SQ_W-3:0], 2'b00};
    if (rem_t >= trial) begin
      nxt.rem = rem_t - trial;
      nxt.root = {cur.root[ppd_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem = rem_t;
      nxt.root = {cur.root[ppd_pkg::ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  logic [ppd_pkg::ROOT_STAGES-1:0] v_q;
  logic [ppd_pkg::ROOT_STAGES-1:0] stg_ready;
  step_t                st_q  [ppd_pkg::ROOT_STAGES];
  ppd_pkg::index_pair_t idx_q [ppd_pkg::ROOT_STAGES];

  for (genvar s = 0; s < ppd_pkg::ROOT_STAGES; s++) begin : g_stage
    logic                 up_v;
    step_t                up_st;
    ppd_pkg::index_pair_t up_idx;
    logic                 down_ready;
    step_t                nxt_st;

    // upstream source
    if (s == 0) begin : g_first
      assign up_v = in_valid_i;
      assign up_st = '{rad: in_item_i.sum, rem: '0, root: '0};
      assign up_idx = in_item_i.idx;
    end else begin : g_next
      assign up_v = v_q[s-1];
      assign up_st = st_q[s-1];
      assign up_idx = idx_q[s-1];
    end

    // downstream ready
    if (s == ppd_pkg::ROOT_STAGES - 1) begin : g_last
      assign down_ready = out_ready_i;
    end else begin : g_mid
      assign down_ready = stg_ready[s+1];
    end

    assign stg_ready[s] = !v_q[s] || down_ready;

    // chained steps of this stage
    always_comb begin
      nxt_st = up_st;
      for (int k = 0; k < ppd_pkg::ROOT_BITS_PER_STAGE; k++) begin
        nxt_st = sqrt_step(nxt_st);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (stg_ready[s]) begin
        v_q[s] <= up_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_ready[s] && up_v) begin
        st_q[s] <= nxt_st;
        idx_q[s] <= up_idx;
      end
    end
  end

  assign in_ready_o = stg_ready[0];
  assign out_valid_o = v_q[ppd_pkg::ROOT_STAGES-1];
  assign out_item_o.root = st_q[ppd_pkg::ROOT_STAGES-1].root;
  assign out_item_o.idx = idx_q[ppd_pkg::ROOT_STAGES-1];

endmodule

`default_nettype wire

// ----- hw/rtl/ppd_scale.sv -----
// back end: box length scaling, rounding, saturation and cutoff test (2 stages)
// depends on ppd_pkg
`default_nettype none

module ppd_scale (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ppd_pkg::root_item_t         in_item_i,
  input  wire logic [ppd_pkg::DIST_W-1:0]  box_length_i,
  input  wire logic [ppd_pkg::DIST_W-1:0]  bond_cutoff_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output ppd_pkg::result_t                 out_item_o
);

  localparam int PROD_W = ppd_pkg::ROOT_W + ppd_pkg::DIST_W;
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (ppd_pkg::ROOT_W - 1);

  logic v1_q, v2_q;
  logic rdy1, rdy2;
  logic [PROD_W-1:0]    prod_q;
  ppd_pkg::index_pair_t idx1_q;
  ppd_pkg::result_t     res_q;

  logic [PROD_W:0]               rounded;
  logic [ppd_pkg::DIST_W:0]      quot;
  logic [ppd_pkg::DIST_W-1:0]    distance;
  logic                          bonded;

  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  // stage 1: root times box length
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      prod_q <= PROD_W'(in_item_i.root) * PROD_W'(box_length_i);
      idx1_q <= in_item_i.idx;
    end
  end

  // round half up back to Q8.16, saturate, compare against cutoff
  always_comb begin
    rounded = {1'b0, prod_q} + ROUND_HALF;
    quot = rounded[PROD_W -: (ppd_pkg::DIST_W + 1)];
    distance = quot[ppd_pkg::DIST_W] ? ppd_pkg::DIST_MAX : quot[ppd_pkg::DIST_W-1:0];
    bonded = distance < bond_cutoff_i;
  end

  // stage 2: output register
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      res_q.distance <= distance;
      res_q.graph <= bonded ? distance : '0;
      res_q.bonded <= bonded;
      res_q.idx <= idx1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_item_o = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/periodic_pair_distance_cutoff.sv -----
// top level of the periodic pair distance block: registers, front end, root, scaling
// depends on ppd_pkg, ppd_front, ppd_root, ppd_scale
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_ready_o   center_*, partner_*, *_index
//   result    out        out_valid_o / out_ready_i pair_distance, graph_value, bonded, out_*
//   config    in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// one transaction enters per cycle while in_ready_o is high; the pipeline has 3 front end
// stages, 12 square root stages at two root bits each and 2 scaling stages
// reset clears all valid bits and loads the register defaults
// a stalled result holds the output register; stages behind it fill their
// empty slots, and input ready falls only when every stage is full
`default_nettype none

module periodic_pair_distance_cutoff (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ppd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ppd_pkg::DIST_W-1:0]       cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [ppd_pkg::COORD_W-1:0]      center_x_i,
  input  wire logic [ppd_pkg::COORD_W-1:0]      center_y_i,
  input  wire logic [ppd_pkg::COORD_W-1:0]      center_z_i,
  input  wire logic [ppd_pkg::COORD_W-1:0]      partner_x_i,
  input  wire logic [ppd_pkg::COORD_W-1:0]      partner_y_i,
  input  wire logic [ppd_pkg::COORD_W-1:0]      partner_z_i,
  input  wire logic [ppd_pkg::INDEX_W-1:0]      center_index_i,
  input  wire logic [ppd_pkg::INDEX_W-1:0]      partner_index_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [ppd_pkg::DIST_W-1:0]            pair_distance_o,
  output logic [ppd_pkg::DIST_W-1:0]            graph_value_o,
  output logic                                  bonded_o,
  output logic [ppd_pkg::INDEX_W-1:0]           out_center_index_o,
  output logic [ppd_pkg::INDEX_W-1:0]           out_partner_index_o
);

  logic [ppd_pkg::DIST_W-1:0] box_length_q;
  logic [ppd_pkg::DIST_W-1:0] bond_cutoff_q;

  ppd_pkg::coord_vec_t  center;
  ppd_pkg::coord_vec_t  partner;
  ppd_pkg::index_pair_t idx;
  ppd_pkg::sum_item_t   sum_item;
  ppd_pkg::root_item_t  root_item;
  ppd_pkg::result_t     result;
  logic sum_valid, sum_ready, root_valid, root_ready;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_length_q <= ppd_pkg::BOX_LENGTH_RESET;
      bond_cutoff_q <= ppd_pkg::BOND_CUTOFF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ppd_pkg::CFG_BOX_LENGTH_SCALE: box_length_q <= cfg_wdata_i;
        ppd_pkg::CFG_BOND_CUTOFF:      bond_cutoff_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pack the input fields
  assign center = {center_z_i, center_y_i, center_x_i};
  assign partner = {partner_z_i, partner_y_i, partner_x_i};
  assign idx = '{center: center_index_i, partner: partner_index_i};

  ppd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .center_i   (center),
    .partner_i  (partner),
    .idx_i      (idx),
    .out_valid_o(sum_valid),
    .out_ready_i(sum_ready),
    .out_item_o (sum_item)
  );

  ppd_root u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sum_valid),
    .in_ready_o (sum_ready),
    .in_item_i  (sum_item),
    .out_valid_o(root_valid),
    .out_ready_i(root_ready),
    .out_item_o (root_item)
  );

  ppd_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (root_valid),
    .in_ready_o    (root_ready),
    .in_item_i     (root_item),
    .box_length_i  (box_length_q),
    .bond_cutoff_i (bond_cutoff_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (result)
  );

  // unpack the result
  assign pair_distance_o = result.distance;
  assign graph_value_o = result.graph;
  assign bonded_o = result.bonded;
  assign out_center_index_o = result.idx.center;
  assign out_partner_index_o = result.idx.partner;

  // input may only stall when the whole pipe is full behind a stalled result
  a_stall_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i)
  ) else $error("input stalled while pipeline has room");

  // graph value follows the bonded flag
  a_graph_matches_bond: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bonded_o ? (graph_value_o == pair_distance_o)
                              : (graph_value_o == '0))
  ) else $error("graph value inconsistent with bonded flag");

  // a bonded pair never carries the saturated distance code
  a_no_bond_at_max: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bonded_o) |-> (pair_distance_o != ppd_pkg::DIST_MAX)
  ) else $error("saturated distance flagged as bonded");

endmodule

`default_nettype wire
